// ----- rtl/trrf_pkg.sv -----
// Package for the trimmed rigid rotation fit block.
// Holds field widths, CORDIC constants, register indexes and the sequencer states.
// No dependencies.
`default_nettype none

package trrf_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_ROUNDS     = 3;

    localparam int COORD_W  = 20;
    localparam int ANGLE_W  = 16;
    localparam int RES_W    = 42;
    localparam int CS_W     = 33;
    localparam int ZW       = 26;
    localparam int MA_W     = 24;
    localparam int MB_W     = 34;
    localparam int MP_W     = MA_W + MB_W;
    localparam int EX_W     = 24;
    localparam int SQ_W     = 47;
    localparam int SUB_W    = 4;
    localparam int IT_W     = 5;
    localparam int ROT_SHIFT = 30;
    localparam int ANG_SHIFT = 8;

    localparam int CORDIC_STEPS  = 20;
    localparam int PI_UNITS      = 8388608;
    localparam int HALF_PI_UNITS = 4194304;
    localparam int GAIN_INV      = 652032874;
    localparam int MIN_INLIERS   = 3;

    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REF_PRESENT = 2'd1;

    localparam logic [15:0] TOL_RESET = 16'd160;

    typedef enum logic [3:0] {
        S_LOAD, S_FLOOR, S_FLOOR_W, S_SUM, S_DIV, S_DOT, S_VEC, S_ANG,
        S_ROT, S_RES, S_MED, S_MED_NEXT, S_CUT, S_KEEP, S_CHECK, S_OUT
    } fit_state_t;

    function automatic logic signed [ZW-1:0] atan_val(input logic [IT_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 26'sd2097152;
            5'd1:  v = 26'sd1238021;
            5'd2:  v = 26'sd654136;
            5'd3:  v = 26'sd332050;
            5'd4:  v = 26'sd166669;
            5'd5:  v = 26'sd83416;
            5'd6:  v = 26'sd41718;
            5'd7:  v = 26'sd20860;
            5'd8:  v = 26'sd10430;
            5'd9:  v = 26'sd5215;
            5'd10: v = 26'sd2608;
            5'd11: v = 26'sd1304;
            5'd12: v = 26'sd652;
            5'd13: v = 26'sd326;
            5'd14: v = 26'sd163;
            5'd15: v = 26'sd81;
            5'd16: v = 26'sd41;
            5'd17: v = 26'sd20;
            5'd18: v = 26'sd10;
            5'd19: v = 26'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/trimmed_rigid_rotation_fit.sv -----
// Trimmed rigid rotation fit: stores point pairs, then fits a rotation with median trimming.
// Depends on trrf_pkg; one shared multiplier, one CORDIC stage and one divider step.
//
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata pairs, s_tuser placed, s_tlast last
// m_        out  m_tvalid/m_tready    m_tdata angle and centroids, m_tuser fit_ok
// cfg_      in   cfg_valid/cfg_ready  cfg_addr register index, cfg_data value
//
// Loading takes one request per cycle. The request with tlast starts the fit of up to
// ROUNDS rounds over the n stored pairs; in each, the median search (42 counting passes
// over the residual memory through its one read port) dominates.
// Reset is synchronous and active low and leaves the block empty and ready.
// s_tready stays low from the last request until its result is in the output register.
`default_nettype none

module trimmed_rigid_rotation_fit
    import trrf_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int ROUNDS     = DEF_ROUNDS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [79:0]           s_tdata,   // rec_x, rec_y, ref_x, ref_y
    input  wire logic [0:0]            s_tuser,   // placed
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [95:0]                m_tdata,   // angle, rec_mean_x, rec_mean_y,
                                                  // ref_mean_x, ref_mean_y
    output logic [0:0]                 m_tuser,   // fit_ok
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int SW    = COORD_W + CNT_W;
    localparam int ACC_W = 2 * COORD_W + 2 + CNT_W;
    localparam int CW    = ACC_W + 2;
    localparam int DIF_W = COORD_W + 1;
    localparam int RND_W = $clog2(ROUNDS + 1);
    localparam int DB_W  = $clog2(SW + 1);

    localparam logic signed [MP_W-1:0] ROT_BIAS = MP_W'(64'sd536870912);

    fit_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SUB_W-1:0]  sub_reg, sub_next;
    logic [RND_W-1:0]  round_reg, round_next;
    logic              first_reg, first_next;
    logic              ok_reg, ok_next;
    logic [15:0]       tol_reg, tol_next;
    logic              refp_reg, refp_next;
    logic [RES_W-1:0]  floor_reg, floor_next;
    logic [RES_W-1:0]  cut_reg, cut_next;
    logic signed [SW-1:0] sum_reg [4];
    logic signed [SW-1:0] sum_next [4];
    logic [CNT_W-1:0]  m_reg, m_next;
    logic signed [COORD_W-1:0] mean_reg [4];
    logic signed [COORD_W-1:0] mean_next [4];
    logic [1:0]        sel_reg, sel_next;
    logic [DB_W-1:0]   dbit_reg, dbit_next;
    logic [SW-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SW-1:0]     quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic signed [ACC_W-1:0] s1_reg, s1_next;
    logic signed [ACC_W-1:0] s2_reg, s2_next;
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;
    logic [IT_W-1:0]   it_reg, it_next;
    logic signed [ANGLE_W-1:0] ang_reg, ang_next;
    logic signed [CS_W-1:0] c_reg, c_next;
    logic signed [CS_W-1:0] s_reg, s_next;
    logic signed [MP_W-1:0] mul_reg;
    logic signed [MP_W-1:0] t_reg, t_next;
    logic signed [EX_W-1:0] ex_reg, ex_next;
    logic signed [EX_W-1:0] ey_reg, ey_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [RES_W-1:0]  lo_reg, lo_next;
    logic [RES_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  kcnt_reg, kcnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [95:0]       m_tdata_reg, m_tdata_next;
    logic              m_ok_reg, m_ok_next;

    logic [79:0]       pt_mem [MAX_POINTS];
    logic [RES_W-1:0]  res_mem [MAX_POINTS];
    logic [79:0]       rd_pt_reg;
    logic [RES_W-1:0]  rd_res_reg;
    logic              pt_we;
    logic              res_we;
    logic [RES_W-1:0]  res_wdata;

    logic signed [COORD_W-1:0] rx, ry, gx, gy;
    logic signed [DIF_W-1:0]   ax, ay, bx, by;
    logic                      inl;
    logic                      pass_last;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [MP_W-1:0]    mul_p;
    logic signed [CW-1:0]      xs, ys, cx_step, cy_step;
    logic signed [ZW-1:0]      cz_step, zr, zrot;
    logic                      sig;
    logic signed [MP_W-1:0]    e_sum, e_full;
    logic [SQ_W:0]             sq_tot;
    logic [RES_W-1:0]          mid;
    logic [CNT_W:0]            rq;
    logic                      ge;
    logic [SW-1:0]             q_fin;
    logic [SW-1:0]             abs_sum;
    logic [CNT_W-1:0]          cnt_inc;

    assign rx = rd_pt_reg[19:0];
    assign ry = rd_pt_reg[39:20];
    assign gx = rd_pt_reg[59:40];
    assign gy = rd_pt_reg[79:60];
    assign ax = DIF_W'(rx) - DIF_W'(mean_reg[0]);
    assign ay = DIF_W'(ry) - DIF_W'(mean_reg[1]);
    assign bx = DIF_W'(gx) - DIF_W'(mean_reg[2]);
    assign by = DIF_W'(gy) - DIF_W'(mean_reg[3]);
    assign inl = first_reg || (rd_res_reg < cut_reg);
    assign pass_last = (CNT_W'(idx_reg) + CNT_W'(1)) == n_reg;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign s_tready  = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_ok_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_FLOOR: begin
                mul_a = MA_W'({1'b0, tol_reg, 1'b0});
                mul_b = MB_W'({1'b0, tol_reg, 1'b0});
            end
            S_DOT: begin
                case (sub_reg)
                    4'd1: begin mul_a = MA_W'(ax); mul_b = MB_W'(bx); end
                    4'd2: begin mul_a = MA_W'(ay); mul_b = MB_W'(by); end
                    4'd3: begin mul_a = MA_W'(ax); mul_b = MB_W'(by); end
                    4'd4: begin mul_a = MA_W'(ay); mul_b = MB_W'(bx); end
                    default: ;
                endcase
            end
            S_RES: begin
                case (sub_reg)
                    4'd1: begin mul_a = MA_W'(ax); mul_b = MB_W'(c_reg); end
                    4'd2: begin mul_a = MA_W'(ay); mul_b = MB_W'(s_reg); end
                    4'd3: begin mul_a = MA_W'(ax); mul_b = MB_W'(s_reg); end
                    4'd4: begin mul_a = MA_W'(ay); mul_b = MB_W'(c_reg); end
                    4'd6: begin mul_a = MA_W'(ex_reg); mul_b = MB_W'(ex_reg); end
                    4'd7: begin mul_a = MA_W'(ey_reg); mul_b = MB_W'(ey_reg); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

    assign sig     = (state_reg == S_ROT) ? !cz_reg[ZW-1] : cy_reg[CW-1];
    assign xs      = cx_reg >>> it_reg;
    assign ys      = cy_reg >>> it_reg;
    assign cx_step = sig ? cx_reg - ys : cx_reg + ys;
    assign cy_step = sig ? cy_reg + xs : cy_reg - xs;
    assign cz_step = sig ? cz_reg - atan_val(it_reg) : cz_reg + atan_val(it_reg);
    assign zr      = (cz_reg + ZW'(128)) >>> ANG_SHIFT;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        sub_next      = sub_reg;
        round_next    = round_reg;
        first_next    = first_reg;
        ok_next       = ok_reg;
        tol_next      = tol_reg;
        refp_next     = refp_reg;
        floor_next    = floor_reg;
        cut_next      = cut_reg;
        sum_next      = sum_reg;
        m_next        = m_reg;
        mean_next     = mean_reg;
        sel_next      = sel_reg;
        dbit_next     = dbit_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        neg_next      = neg_reg;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        it_next       = it_reg;
        ang_next      = ang_reg;
        c_next        = c_reg;
        s_next        = s_reg;
        t_next        = t_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        sq_next       = sq_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        kcnt_next     = kcnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_ok_next     = m_ok_reg;
        pt_we         = 1'b0;
        res_we        = 1'b0;
        res_wdata     = '0;
        e_sum         = '0;
        e_full        = '0;
        sq_tot        = '0;
        rq            = '0;
        ge            = 1'b0;
        q_fin         = '0;
        abs_sum       = '0;
        cnt_inc       = cnt_reg;
        zrot          = '0;

        if (cfg_valid) begin
            case (cfg_addr)
                REG_TOLERANCE:   tol_next  = cfg_data;
                REG_REF_PRESENT: refp_next = cfg_data[0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    if (s_tuser[0] && (cnt_reg < CNT_W'(MAX_POINTS))) begin
                        pt_we   = 1'b1;
                        cnt_inc = cnt_reg + CNT_W'(1);
                    end
                    cnt_next = cnt_inc;
                    if (s_tlast) begin
                        n_next  = cnt_inc;
                        ok_next = refp_reg && (cnt_inc >= CNT_W'(MIN_INLIERS));
                        state_next = (refp_reg && (cnt_inc >= CNT_W'(MIN_INLIERS))) ?
                                     S_FLOOR : S_OUT;
                    end
                end
            end
            S_FLOOR: begin
                state_next = S_FLOOR_W;
            end
            S_FLOOR_W: begin
                floor_next = mul_reg[RES_W-1:0];
                first_next = 1'b1;
                round_next = '0;
                idx_next   = '0;
                sub_next   = '0;
                for (int k = 0; k < 4; k++) sum_next[k] = '0;
                m_next     = '0;
                state_next = S_SUM;
            end
            S_SUM: begin
                if (sub_reg == '0) begin
                    sub_next = 4'd1;
                end else begin
                    if (inl) begin
                        sum_next[0] = sum_reg[0] + SW'(rx);
                        sum_next[1] = sum_reg[1] + SW'(ry);
                        sum_next[2] = sum_reg[2] + SW'(gx);
                        sum_next[3] = sum_reg[3] + SW'(gy);
                        m_next = m_reg + CNT_W'(1);
                    end
                    sub_next = '0;
                    if (pass_last) begin
                        sel_next   = '0;
                        dbit_next  = '0;
                        state_next = S_DIV;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_DIV: begin
                if (dbit_reg == '0) begin
                    abs_sum   = sum_reg[sel_reg][SW-1] ? SW'(-sum_reg[sel_reg]) :
                                SW'(sum_reg[sel_reg]);
                    dvd_next  = abs_sum + SW'(m_reg >> 1);
                    neg_next  = sum_reg[sel_reg][SW-1];
                    rem_next  = '0;
                    quo_next  = '0;
                    dbit_next = DB_W'(SW);
                end else begin
                    rq        = {rem_reg, dvd_reg[SW-1]};
                    ge        = rq >= {1'b0, m_reg};
                    rem_next  = ge ? CNT_W'(rq - {1'b0, m_reg}) : CNT_W'(rq);
                    dvd_next  = dvd_reg << 1;
                    q_fin     = {quo_reg[SW-2:0], ge};
                    quo_next  = q_fin;
                    dbit_next = dbit_reg - DB_W'(1);
                    if (dbit_reg == DB_W'(1)) begin
                        mean_next[sel_reg] = neg_reg ? COORD_W'(-q_fin[COORD_W-1:0]) :
                                             q_fin[COORD_W-1:0];
                        dbit_next = '0;
                        if (sel_reg == 2'd3) begin
                            idx_next   = '0;
                            sub_next   = '0;
                            s1_next    = '0;
                            s2_next    = '0;
                            state_next = S_DOT;
                        end else begin
                            sel_next = sel_reg + 2'd1;
                        end
                    end
                end
            end
            S_DOT: begin
                case (sub_reg)
                    4'd0: sub_next = 4'd1;
                    4'd1: sub_next = 4'd2;
                    4'd2: begin s1_next = s1_reg + ACC_W'(mul_reg); sub_next = 4'd3; end
                    4'd3: begin s1_next = s1_reg + ACC_W'(mul_reg); sub_next = 4'd4; end
                    4'd4: begin s2_next = s2_reg + ACC_W'(mul_reg); sub_next = 4'd5; end
                    default: s2_next = s2_reg - ACC_W'(mul_reg);
                endcase
                if ((sub_reg == 4'd5) || ((sub_reg == 4'd1) && !inl)) begin
                    sub_next = '0;
                    if (pass_last) begin
                        state_next = S_VEC;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_VEC: begin
                if (sub_reg == '0) begin
                    sub_next = 4'd1;
                    it_next  = '0;
                    if ((s1_reg == '0) && (s2_reg == '0)) begin
                        cz_next    = '0;
                        state_next = S_ANG;
                    end else if (s1_reg[ACC_W-1]) begin
                        cx_next = -CW'(s1_reg);
                        cy_next = -CW'(s2_reg);
                        cz_next = s2_reg[ACC_W-1] ? -ZW'(PI_UNITS) : ZW'(PI_UNITS);
                    end else begin
                        cx_next = CW'(s1_reg);
                        cy_next = CW'(s2_reg);
                        cz_next = '0;
                    end
                end else begin
                    cx_next = cx_step;
                    cy_next = cy_step;
                    cz_next = cz_step;
                    it_next = it_reg + IT_W'(1);
                    if (it_reg == IT_W'(CORDIC_STEPS - 1)) begin
                        state_next = S_ANG;
                    end
                end
            end
            S_ANG: begin
                ang_next = zr[ANGLE_W-1:0];
                zrot     = ZW'($signed({zr[ANGLE_W-1:0], 8'b0}));
                it_next  = '0;
                if (zrot > ZW'(HALF_PI_UNITS)) begin
                    cx_next = '0;
                    cy_next = CW'(GAIN_INV);
                    cz_next = zrot - ZW'(HALF_PI_UNITS);
                end else if (zrot < -ZW'(HALF_PI_UNITS)) begin
                    cx_next = '0;
                    cy_next = -CW'(GAIN_INV);
                    cz_next = zrot + ZW'(HALF_PI_UNITS);
                end else begin
                    cx_next = CW'(GAIN_INV);
                    cy_next = '0;
                    cz_next = zrot;
                end
                state_next = S_ROT;
            end
            S_ROT: begin
                cx_next = cx_step;
                cy_next = cy_step;
                cz_next = cz_step;
                it_next = it_reg + IT_W'(1);
                if (it_reg == IT_W'(CORDIC_STEPS - 1)) begin
                    c_next     = cx_step[CS_W-1:0];
                    s_next     = cy_step[CS_W-1:0];
                    idx_next   = '0;
                    sub_next   = '0;
                    state_next = S_RES;
                end
            end
            S_RES: begin
                sub_next = sub_reg + SUB_W'(1);
                case (sub_reg)
                    4'd2: t_next = mul_reg;
                    4'd3: begin
                        e_sum   = t_reg - mul_reg + ROT_BIAS;
                        e_full  = (e_sum >>> ROT_SHIFT) + MP_W'(mean_reg[2]) - MP_W'(gx);
                        ex_next = e_full[EX_W-1:0];
                    end
                    4'd4: t_next = mul_reg;
                    4'd5: begin
                        e_sum   = t_reg + mul_reg + ROT_BIAS;
                        e_full  = (e_sum >>> ROT_SHIFT) + MP_W'(mean_reg[3]) - MP_W'(gy);
                        ey_next = e_full[EX_W-1:0];
                    end
                    4'd7: sq_next = mul_reg[SQ_W-1:0];
                    4'd8: begin
                        sq_tot    = {1'b0, sq_reg} + {1'b0, mul_reg[SQ_W-1:0]};
                        res_we    = 1'b1;
                        res_wdata = (sq_tot > (SQ_W+1)'(RES_MAX)) ? RES_MAX :
                                    sq_tot[RES_W-1:0];
                        sub_next  = '0;
                        if (pass_last) begin
                            lo_next    = '0;
                            hi_next    = RES_MAX;
                            idx_next   = '0;
                            kcnt_next  = '0;
                            state_next = S_MED;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            S_MED: begin
                if (sub_reg == '0) begin
                    sub_next = 4'd1;
                end else begin
                    if (rd_res_reg <= mid) kcnt_next = kcnt_reg + CNT_W'(1);
                    sub_next = '0;
                    if (pass_last) begin
                        state_next = S_MED_NEXT;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_MED_NEXT: begin
                if (kcnt_reg > (n_reg >> 1)) begin
                    hi_next = mid;
                    state_next = (lo_reg < mid) ? S_MED : S_CUT;
                end else begin
                    lo_next = mid + RES_W'(1);
                    state_next = ((mid + RES_W'(1)) < hi_reg) ? S_MED : S_CUT;
                end
                idx_next  = '0;
                sub_next  = '0;
                kcnt_next = '0;
            end
            S_CUT: begin
                cut_next   = (floor_reg > lo_reg) ? floor_reg : lo_reg;
                idx_next   = '0;
                sub_next   = '0;
                kcnt_next  = '0;
                state_next = S_KEEP;
            end
            S_KEEP: begin
                if (sub_reg == '0) begin
                    sub_next = 4'd1;
                end else begin
                    if (rd_res_reg < cut_reg) kcnt_next = kcnt_reg + CNT_W'(1);
                    sub_next = '0;
                    if (pass_last) begin
                        state_next = S_CHECK;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_CHECK: begin
                first_next = 1'b0;
                round_next = round_reg + RND_W'(1);
                if ((kcnt_reg < CNT_W'(MIN_INLIERS)) || (round_reg == RND_W'(ROUNDS - 1))) begin
                    state_next = S_OUT;
                end else begin
                    idx_next = '0;
                    sub_next = '0;
                    for (int k = 0; k < 4; k++) sum_next[k] = '0;
                    m_next     = '0;
                    state_next = S_SUM;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg) begin
                    m_tvalid_next = 1'b1;
                    m_ok_next     = ok_reg;
                    m_tdata_next  = ok_reg ? {mean_reg[3], mean_reg[2], mean_reg[1],
                                              mean_reg[0], ang_reg} : '0;
                    cnt_next      = '0;
                    state_next    = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            tol_reg      <= TOL_RESET;
            refp_reg     <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            tol_reg      <= tol_next;
            refp_reg     <= refp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        sub_reg     <= sub_next;
        round_reg   <= round_next;
        first_reg   <= first_next;
        ok_reg      <= ok_next;
        floor_reg   <= floor_next;
        cut_reg     <= cut_next;
        sum_reg     <= sum_next;
        m_reg       <= m_next;
        mean_reg    <= mean_next;
        sel_reg     <= sel_next;
        dbit_reg    <= dbit_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        it_reg      <= it_next;
        ang_reg     <= ang_next;
        c_reg       <= c_next;
        s_reg       <= s_next;
        mul_reg     <= mul_p;
        t_reg       <= t_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        sq_reg      <= sq_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        kcnt_reg    <= kcnt_next;
        m_tdata_reg <= m_tdata_next;
        m_ok_reg    <= m_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[cnt_reg[IDX_W-1:0]] <= s_tdata;
        end
        rd_pt_reg <= pt_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (res_we) begin
            res_mem[idx_reg] <= res_wdata;
        end
        rd_res_reg <= res_mem[idx_reg];
    end

endmodule

`default_nettype wire

// ----- rtl/trrf_checker.sv -----
// Port-level checks for the trimmed rigid rotation fit block, bound to its top level.
// Imports trrf_pkg, though its ports take no widths from it.
`default_nettype none

module trrf_checker
    import trrf_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  s_tlast,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [95:0]           m_tdata,
    input wire logic [0:0]            m_tuser
);

    // A result that is not taken holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The input is closed right after the last request of a set is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after the last request");

    // A failed fit reports all fields as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("failed fit with nonzero fields");

    // The block comes out of reset empty and ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> s_tready && !m_tvalid)
        else $error("not ready after reset");

endmodule

bind trimmed_rigid_rotation_fit trrf_checker u_trrf_checker (.*);

`default_nettype wire

// ----- sim/trrf_fit_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for trimmed_rigid_rotation_fit: watches the input, result and register
// channels, predicts each fit from the accepted pairs and compares field by field.
// Depends on trrf_pkg for widths, CORDIC constants and register indexes.
module trrf_fit_checker
    import trrf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [79:0]           s_tdata,
    input  wire logic [0:0]            s_tuser,
    input  wire logic                  s_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [95:0]           m_tdata,
    input  wire logic [0:0]            m_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         fits_pending,
    output int                         fits_checked
);

    localparam int STORE_DEPTH = DEF_MAX_POINTS;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [COORD_W-1:0] rec_mx;
        logic signed [COORD_W-1:0] rec_my;
        logic signed [COORD_W-1:0] ref_mx;
        logic signed [COORD_W-1:0] ref_my;
        logic                      ok;
    } alignment_t;

    alignment_t  expected_fits[$];
    longint      rec_xs[STORE_DEPTH];
    longint      rec_ys[STORE_DEPTH];
    longint      ref_xs[STORE_DEPTH];
    longint      ref_ys[STORE_DEPTH];
    bit          keep[STORE_DEPTH];
    longint unsigned resid[STORE_DEPTH];
    int          stored;
    logic [15:0] tol;
    logic        ref_on;

    assign fits_pending = expected_fits.size();

    function automatic longint round_div(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_UNITS : -PI_UNITS;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_val(i[IT_W-1:0]);
            end else begin
                x -= ys; y += xs; z -= atan_val(i[IT_W-1:0]);
            end
        end
        return z;
    endfunction

    task automatic rotate_unit(input longint ang, output longint c, output longint s);
        longint z, x, y, xs, ys;
        z = ang * 256;
        if (z > HALF_PI_UNITS) begin
            x = 0; y = GAIN_INV; z -= HALF_PI_UNITS;
        end else if (z < -HALF_PI_UNITS) begin
            x = 0; y = -GAIN_INV; z += HALF_PI_UNITS;
        end else begin
            x = GAIN_INV; y = 0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_val(i[IT_W-1:0]);
            end else begin
                x += ys; y -= xs; z += atan_val(i[IT_W-1:0]);
            end
        end
        c = x;
        s = y;
    endtask

    task automatic predict_alignment(output alignment_t r);
        longint ang, mrx, mry, mgx, mgy, sx, sy, gx, gy, m, s1, s2, c, s, z;
        longint ax, ay, bx, by, ex, ey;
        longint unsigned floor_cut, cut, sq;
        longint unsigned ranked[$];
        logic [15:0] a16;
        int kept;
        ang = 0; mrx = 0; mry = 0; mgx = 0; mgy = 0;
        r.ok = 1'b0;
        if (ref_on && stored >= MIN_INLIERS) begin
            floor_cut = longint'(tol) * 2;
            floor_cut = floor_cut * floor_cut;
            for (int i = 0; i < stored; i++) keep[i] = 1'b1;
            for (int rd = 0; rd < DEF_ROUNDS; rd++) begin
                sx = 0; sy = 0; gx = 0; gy = 0; m = 0; s1 = 0; s2 = 0; kept = 0;
                for (int i = 0; i < stored; i++) begin
                    if (keep[i]) begin
                        sx += rec_xs[i]; sy += rec_ys[i];
                        gx += ref_xs[i]; gy += ref_ys[i];
                        m++;
                    end
                end
                mrx = round_div(sx, m); mry = round_div(sy, m);
                mgx = round_div(gx, m); mgy = round_div(gy, m);
                for (int i = 0; i < stored; i++) begin
                    if (keep[i]) begin
                        ax = rec_xs[i] - mrx; ay = rec_ys[i] - mry;
                        bx = ref_xs[i] - mgx; by = ref_ys[i] - mgy;
                        s1 += ax * bx + ay * by;
                        s2 += ax * by - ay * bx;
                    end
                end
                z = (vector_angle(s1, s2) + 128) >>> ANG_SHIFT;
                a16 = z[15:0];
                ang = longint'($signed(a16));
                rotate_unit(ang, c, s);
                ranked.delete();
                for (int i = 0; i < stored; i++) begin
                    ax = rec_xs[i] - mrx;
                    ay = rec_ys[i] - mry;
                    ex = ((ax * c - ay * s + 536870912) >>> ROT_SHIFT) + mgx - ref_xs[i];
                    ey = ((ax * s + ay * c + 536870912) >>> ROT_SHIFT) + mgy - ref_ys[i];
                    sq = longint'(ex * ex) + longint'(ey * ey);
                    resid[i] = (sq > RES_MAX) ? RES_MAX : sq;
                    ranked.insert(ranked.size(), resid[i]);
                end
                ranked.sort();
                cut = ranked[stored / 2];
                if (floor_cut > cut) cut = floor_cut;
                for (int i = 0; i < stored; i++) begin
                    keep[i] = resid[i] < cut;
                    if (keep[i]) kept++;
                end
                if (kept < MIN_INLIERS) break;
            end
            r.ok = 1'b1;
        end
        r.angle = ang[15:0];
        r.rec_mx = mrx[19:0];
        r.rec_my = mry[19:0];
        r.ref_mx = mgx[19:0];
        r.ref_my = mgy[19:0];
        stored = 0;
    endtask

    always @(posedge aclk) begin
        alignment_t want, got;
        if (!aresetn) begin
            stored = 0;
            tol = TOL_RESET;
            ref_on = 1'b1;
            fail_count = 0;
            fits_checked = 0;
            expected_fits.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == REG_TOLERANCE) tol = cfg_data;
                else if (cfg_addr == REG_REF_PRESENT) ref_on = cfg_data[0];
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] && stored < STORE_DEPTH) begin
                    rec_xs[stored] = longint'($signed(s_tdata[19:0]));
                    rec_ys[stored] = longint'($signed(s_tdata[39:20]));
                    ref_xs[stored] = longint'($signed(s_tdata[59:40]));
                    ref_ys[stored] = longint'($signed(s_tdata[79:60]));
                    stored++;
                end
                if (s_tlast) begin
                    predict_alignment(want);
                    expected_fits.insert(expected_fits.size(), want);
                end
            end
            if (m_tvalid && m_tready) begin
                got.angle = m_tdata[15:0];
                got.rec_mx = m_tdata[35:16];
                got.rec_my = m_tdata[55:36];
                got.ref_mx = m_tdata[75:56];
                got.ref_my = m_tdata[95:76];
                got.ok = m_tuser[0];
                fits_checked++;
                if (expected_fits.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result angle %0d ok %0b",
                                 $realtime, got.angle, got.ok);
                end else begin
                    want = expected_fits.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch exp ang %0d rec %0d,%0d ref %0d,%0d ok %0b",
                                      " / got ang %0d rec %0d,%0d ref %0d,%0d ok %0b"},
                                     $realtime, want.angle, want.rec_mx, want.rec_my,
                                     want.ref_mx, want.ref_my, want.ok, got.angle,
                                     got.rec_mx, got.rec_my, got.ref_mx, got.ref_my, got.ok);
                    end
                end
            end
        end
    end

endmodule

// ----- sim/trimmed_rigid_rotation_fit_tb.sv -----
`timescale 1ns / 1ps
// Top of the trimmed_rigid_rotation_fit testbench: clock, reset, stimulus and verdict.
// Depends on trrf_pkg, the block itself and the trrf_fit_checker scoreboard.
module trimmed_rigid_rotation_fit_tb;
    import trrf_pkg::*;

    localparam int STALL_LIMIT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [95:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count, fits_pending, fits_checked;
    int                    requests_sent = 0, sets_sent = 0, idle_cycles = 0;
    bit                    quiet = 0, hold_req = 0;

    always #5 aclk = ~aclk;

    trimmed_rigid_rotation_fit dut (.*);

    trrf_fit_checker checker_i (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[trimmed_rigid_rotation_fit] ERROR");
            $finish;
        end
    end

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (8000) @(negedge aclk);
                hold_req = 0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_pair(input logic [19:0] rx, ry, gx, gy, input bit placed, last);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {gy, gx, ry, rx};
        s_tuser <= placed;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        if (last) sets_sent++;
    endtask

    task automatic settle_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (fits_pending == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
        settle_block();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [19:0] wild_coord();
        case ($urandom_range(0, 5))
            0: return 20'h7FFFF;
            1: return 20'h80000;
            default: return 20'($urandom);
        endcase
    endfunction

    // A shaped set maps the reconstructed points onto the reference by a rotation through a
    // multiple of a quarter turn, a shift and small noise, with an occasional outlier among them.
    task automatic send_set(input int len, input bit shaped, input int spread);
        int rx, ry, gx, gy, tx, ty, turn;
        tx = $urandom_range(0, 20000) - 10000;
        ty = $urandom_range(0, 20000) - 10000;
        turn = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            if (!shaped) begin
                send_pair(wild_coord(), wild_coord(), wild_coord(), wild_coord(),
                          $urandom_range(0, 9) != 0, i == len - 1);
            end else begin
                rx = $urandom_range(0, 2 * spread) - spread;
                ry = $urandom_range(0, 2 * spread) - spread;
                case (turn)
                    0: begin gx = rx;  gy = ry;  end
                    1: begin gx = -ry; gy = rx;  end
                    2: begin gx = -rx; gy = -ry; end
                    default: begin gx = ry; gy = -rx; end
                endcase
                gx += tx + $urandom_range(0, 128) - 64;
                gy += ty + $urandom_range(0, 128) - 64;
                if ($urandom_range(0, 5) == 0) begin
                    gx = $urandom_range(0, 400000) - 200000;
                    gy = $urandom_range(0, 400000) - 200000;
                end
                send_pair(20'(rx), 20'(ry), 20'(gx), 20'(gy),
                          $urandom_range(0, 11) != 0, i == len - 1);
            end
        end
    endtask

    initial begin
        int phase;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_pair(20'h7FFFF, 20'h80000, 20'h80000, 20'h7FFFF, 1, 0);
        send_pair(20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000, 1, 0);
        send_pair(20'h00000, 20'hFFFFF, 20'h00001, 20'h00000, 1, 1);
        send_pair(20'd100, 20'd200, 20'd300, 20'd400, 1, 0);
        send_pair(20'd500, 20'd600, 20'd700, 20'd800, 0, 0);
        send_pair(20'd900, 20'd100, 20'd50, 20'd60, 1, 1);
        send_pair(20'd0, 20'd0, 20'd0, 20'd0, 0, 1);
        for (int i = 0; i < 4; i++)
            send_pair(20'd1234, 20'hFFF00, 20'd77, 20'd5, 1, i == 3);
        send_pair(20'd16, 20'd0, 20'd0, 20'd16, 1, 0);
        send_pair(20'd0, 20'd16, 20'hFFFF0, 20'd0, 1, 0);
        send_pair(20'hFFFF0, 20'd0, 20'd0, 20'hFFFF0, 1, 0);
        send_pair(20'd0, 20'hFFFF0, 20'd16, 20'd0, 1, 1);
        write_reg(REG_REF_PRESENT, 16'd0);
        send_set(5, 1, 5000);
        write_reg(REG_REF_PRESENT, 16'd1);
        write_reg(REG_TOLERANCE, 16'hFFFF);
        send_set(6, 1, 5000);

        phase = 0;
        while (requests_sent < 1850) begin
            if (requests_sent > 1600) quiet = 1;
            case (phase % 5)
                0: write_reg(REG_TOLERANCE, 16'd0);
                1: write_reg(REG_TOLERANCE, 16'($urandom_range(0, 600)));
                2: write_reg(REG_TOLERANCE, TOL_RESET);
                3: write_reg(REG_TOLERANCE, 16'($urandom));
                default: begin
                    write_reg(REG_REF_PRESENT, 16'd0);
                    send_set($urandom_range(1, 6), 1, 3000);
                    write_reg(REG_REF_PRESENT, 16'($urandom_range(0, 1) | 16'hFFFE));
                end
            endcase
            if (phase == 3) hold_req = 1;
            if (phase == 6) send_set(262, 1, 3000);
            for (int k = 0; k < 8; k++) begin
                if ($urandom_range(0, 7) == 0)
                    send_set($urandom_range(1, 10), 0, 0);
                else
                    send_set($urandom_range(1, 14), 1, $urandom_range(0, 1) ? 200000 : 2000);
            end
            phase++;
        end

        settle_block();
        repeat (200) @(posedge aclk);
        $display("Sent %0d pair requests in %0d sets; %0d fits checked over %0d config phases.",
                 requests_sent, sets_sent, fits_checked, phase);
        if (fail_count == 0 && fits_pending == 0)
            $display("[trimmed_rigid_rotation_fit] OK");
        else
            $display("[trimmed_rigid_rotation_fit] ERROR");
        $finish;
    end

endmodule
